[src/trb_pkg.sv]
// Shared types and fixed field widths for the triangle region binner.
// No dependencies; every other file takes names from here by scope.
package trb_pkg;

    localparam int COORD_W = 20;
    localparam int ROW_W   = 4;
    localparam int MASK_W  = 16;

    // One triangle: three vertex positions
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
    } t_tri_item;

    // One row result
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] column_mask;
        logic              last;
    } t_row_item;

endpackage

[src/trb_if.sv]
// Valid/ready channel interfaces for triangle items and row result items.
// Depends on trb_pkg for the payload types.
interface trb_tri_if;
    logic                 valid;
    logic                 ready;
    trb_pkg::t_tri_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface trb_row_if;
    logic                 valid;
    logic                 ready;
    trb_pkg::t_row_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/triangle_region_binner.sv]
// The first row item is registered through F1, F2, F3, G, R1 and R2 after
// acceptance. One row item per cycle while o_row.ready holds; a triangle
// issues one item per row of its clamped bounding box (whole-map mode: a
// single item), set by the row sequencer G that holds it while rows issue.
// Reset: synchronous active-low i_rst_n empties all stages, whole_map_mode=0.
// Top level; depends on trb_pkg and the interfaces in trb_if.sv.
module triangle_region_binner #(
    parameter int GRID_DIM     = 16,
    parameter int REGION_SHIFT = 10,
    parameter int COORD_FRAC   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    trb_tri_if.sink     i_tri,
    trb_row_if.source   o_row
);

    localparam int CW   = trb_pkg::COORD_W;
    localparam int CS   = REGION_SHIFT + COORD_FRAC;
    localparam int RW   = $clog2(GRID_DIM);
    localparam int CIW  = $clog2(GRID_DIM + 1);
    localparam int XW   = (CS + CIW + 1 > CW) ? CS + CIW + 1 : CW;
    localparam int DW   = XW + 1;
    localparam int PW   = 2 * DW;
    localparam int MW   = 2 * DW + 2;
    localparam int LPW  = DW + CIW + 2;

    // Configuration register
    logic r_whole_map;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole_map <= 1'b0;
        end else if (i_cfg_we) begin
            r_whole_map <= i_cfg_wdata;
        end
    end

    // Stage handshake signals
    logic r_f1_v, r_f2_v, r_f3_v, r_g_v, r_r1_v, r_r2_v;
    logic f1_rdy, f2_rdy, f3_rdy, g_rdy, r1_rdy, r2_rdy;
    logic g_emit, g_last, g_load;

    assign r2_rdy = !r_r2_v || o_row.ready;
    assign r1_rdy = !r_r1_v || r2_rdy;
    assign g_emit = r_g_v && r1_rdy;
    assign g_rdy  = !r_g_v || (g_emit && g_last);
    assign f3_rdy = !r_f3_v || g_rdy;
    assign f2_rdy = !r_f2_v || f3_rdy;
    assign f1_rdy = !r_f1_v || f2_rdy;
    assign i_tri.ready = f1_rdy;
    assign g_load = r_f3_v && g_rdy;

    // F1: capture the triangle and the mode
    logic signed [CW-1:0] r_f1_x [3];
    logic signed [CW-1:0] r_f1_y [3];
    logic                 r_f1_wm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (f1_rdy) begin
            r_f1_v <= i_tri.valid;
        end
        if (f1_rdy && i_tri.valid) begin
            r_f1_x[0] <= i_tri.data.a_x;
            r_f1_y[0] <= i_tri.data.a_y;
            r_f1_x[1] <= i_tri.data.b_x;
            r_f1_y[1] <= i_tri.data.b_y;
            r_f1_x[2] <= i_tri.data.c_x;
            r_f1_y[2] <= i_tri.data.c_y;
            r_f1_wm   <= r_whole_map;
        end
    end

    // F2: the two products of the signed area
    logic signed [DW-1:0] n_bax, n_cay, n_bay, n_cax;
    logic signed [PW-1:0] n_f2_p1, n_f2_p2;
    always_comb begin
        n_bax   = DW'(r_f1_x[1]) - DW'(r_f1_x[0]);
        n_cay   = DW'(r_f1_y[2]) - DW'(r_f1_y[0]);
        n_bay   = DW'(r_f1_y[1]) - DW'(r_f1_y[0]);
        n_cax   = DW'(r_f1_x[2]) - DW'(r_f1_x[0]);
        n_f2_p1 = n_bax * n_cay;
        n_f2_p2 = n_bay * n_cax;
    end

    logic signed [CW-1:0] r_f2_x [3];
    logic signed [CW-1:0] r_f2_y [3];
    logic signed [PW-1:0] r_f2_p1, r_f2_p2;
    logic                 r_f2_wm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (f2_rdy) begin
            r_f2_v <= r_f1_v;
        end
        if (f2_rdy && r_f1_v) begin
            r_f2_x  <= r_f1_x;
            r_f2_y  <= r_f1_y;
            r_f2_p1 <= n_f2_p1;
            r_f2_p2 <= n_f2_p2;
            r_f2_wm <= r_f1_wm;
        end
    end

    // F3: fix the winding by swapping a and c on positive area
    logic signed [PW:0] n_area;
    logic               n_swap;
    assign n_area = (PW+1)'(r_f2_p1) - (PW+1)'(r_f2_p2);
    assign n_swap = n_area > 0;

    logic signed [CW-1:0] r_f3_x [3];
    logic signed [CW-1:0] r_f3_y [3];
    logic                 r_f3_wm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else if (f3_rdy) begin
            r_f3_v <= r_f2_v;
        end
        if (f3_rdy && r_f2_v) begin
            r_f3_x[0] <= n_swap ? r_f2_x[2] : r_f2_x[0];
            r_f3_y[0] <= n_swap ? r_f2_y[2] : r_f2_y[0];
            r_f3_x[1] <= r_f2_x[1];
            r_f3_y[1] <= r_f2_y[1];
            r_f3_x[2] <= n_swap ? r_f2_x[0] : r_f2_x[2];
            r_f3_y[2] <= n_swap ? r_f2_y[0] : r_f2_y[2];
            r_f3_wm   <= r_f2_wm;
        end
    end

    // Floor-divide a coordinate into a cell index and clamp it to the grid
    function automatic logic [RW-1:0] cell_of(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic [RW-1:0]        c;
        s = v >>> CS;
        if (s < 0) begin
            c = '0;
        end else if (s > GRID_DIM - 1) begin
            c = RW'(GRID_DIM - 1);
        end else begin
            c = RW'(s);
        end
        return c;
    endfunction

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Edge setup for a->b, b->c, c->a and the clamped bounding box
    logic signed [DW-1:0] n_ex [3];
    logic signed [DW-1:0] n_ey [3];
    logic signed [PW-1:0] n_k  [3];
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            n_ex[e] = DW'(r_f3_x[(e+1)%3]) - DW'(r_f3_x[e]);
            n_ey[e] = DW'(r_f3_y[(e+1)%3]) - DW'(r_f3_y[e]);
            n_k[e]  = n_ey[e] * DW'(r_f3_x[e]);
        end
    end

    // G: row sequencer, holds one triangle while its rows issue
    logic signed [DW-1:0] r_g_ex [3];
    logic signed [DW-1:0] r_g_ey [3];
    logic signed [CW-1:0] r_g_py [3];
    logic signed [PW-1:0] r_g_k  [3];
    logic [RW-1:0]        r_g_row, r_g_maxy, r_g_minx, r_g_maxx;
    logic                 r_g_wm;

    assign g_last = r_g_wm || (r_g_row == r_g_maxy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (g_rdy) begin
            r_g_v <= r_f3_v;
        end
        if (g_load) begin
            r_g_ex   <= n_ex;
            r_g_ey   <= n_ey;
            r_g_py   <= r_f3_y;
            r_g_k    <= n_k;
            r_g_row  <= cell_of(min3(r_f3_y[0], r_f3_y[1], r_f3_y[2]));
            r_g_maxy <= cell_of(max3(r_f3_y[0], r_f3_y[1], r_f3_y[2]));
            r_g_minx <= cell_of(min3(r_f3_x[0], r_f3_x[1], r_f3_x[2]));
            r_g_maxx <= cell_of(max3(r_f3_x[0], r_f3_x[1], r_f3_x[2]));
            r_g_wm   <= r_f3_wm;
        end else if (g_emit && !g_last) begin
            r_g_row <= r_g_row + RW'(1);
        end
    end

    // R1: per-edge row term at the row corner that minimizes the edge function
    logic [CIW-1:0]       n_ycell [3];
    logic signed [XW-1:0] n_ysel  [3];
    logic signed [DW-1:0] n_yd    [3];
    logic signed [PW-1:0] n_yp    [3];
    logic signed [MW-1:0] n_base  [3];
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            n_ycell[e] = CIW'(r_g_row) + CIW'(!(r_g_ex[e] > 0));
            n_ysel[e]  = XW'(n_ycell[e]) << CS;
            n_yd[e]    = DW'(n_ysel[e]) - DW'(r_g_py[e]);
            n_yp[e]    = r_g_ex[e] * n_yd[e];
            n_base[e]  = MW'(n_yp[e]) + MW'(r_g_k[e]);
        end
    end

    logic signed [MW-1:0] r_r1_base [3];
    logic signed [DW-1:0] r_r1_ey   [3];
    logic [RW-1:0]        r_r1_row, r_r1_minx, r_r1_maxx;
    logic                 r_r1_last, r_r1_wm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
        end else if (r1_rdy) begin
            r_r1_v <= r_g_v;
        end
        if (g_emit) begin
            r_r1_base <= n_base;
            r_r1_ey   <= r_g_ey;
            r_r1_row  <= r_g_row;
            r_r1_minx <= r_g_minx;
            r_r1_maxx <= r_g_maxx;
            r_r1_last <= g_last;
            r_r1_wm   <= r_g_wm;
        end
    end

    // R2: one lane per column; a region is hit when the column is in the box
    // and every edge is negative at its minimizing corner
    logic [GRID_DIM-1:0]   n_mask;
    logic [CIW:0]          n_xs;
    logic signed [LPW-1:0] n_lp;
    logic signed [MW-1:0]  n_ev;
    logic                  n_hit;
    always_comb begin
        n_mask = '0;
        n_xs   = '0;
        n_lp   = '0;
        n_ev   = '0;
        n_hit  = 1'b0;
        for (int c = 0; c < GRID_DIM; c++) begin
            n_hit = (c >= int'(r_r1_minx)) && (c <= int'(r_r1_maxx));
            for (int e = 0; e < 3; e++) begin
                n_xs  = (CIW+1)'(c) + (CIW+1)'(r_r1_ey[e] >= 0);
                n_lp  = r_r1_ey[e] * $signed({1'b0, n_xs});
                n_ev  = r_r1_base[e] - (MW'(n_lp) <<< CS);
                n_hit = n_hit && (n_ev < 0);
            end
            n_mask[c] = n_hit;
        end
    end

    trb_pkg::t_row_item r_r2_item;
    logic               r_r2_wm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2_v <= 1'b0;
        end else if (r2_rdy) begin
            r_r2_v <= r_r1_v;
        end
        if (r2_rdy && r_r1_v) begin
            r_r2_wm <= r_r1_wm;
            if (r_r1_wm) begin
                r_r2_item.row         <= '0;
                r_r2_item.column_mask <= trb_pkg::MASK_W'(1);
                r_r2_item.last        <= 1'b1;
            end else begin
                r_r2_item.row         <= trb_pkg::ROW_W'(r_r1_row);
                r_r2_item.column_mask <= trb_pkg::MASK_W'(n_mask);
                r_r2_item.last        <= r_r1_last;
            end
        end
    end

    assign o_row.valid = r_r2_v;
    assign o_row.data  = r_r2_item;

    // Checks
    a_wm_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r2_v && r_r2_wm) |-> (r_r2_item.last && r_r2_item.row == '0))
        else $error("whole-map item is not a single row-zero item");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_v && !r_g_wm) |-> (r_g_row <= r_g_maxy))
        else $error("row sequencer passed the last row");

    a_seq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g_emit && g_last && !r_f3_v) |=> !r_g_v)
        else $error("row sequencer kept a finished triangle");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g_emit && !g_last) |=> (r_g_v && r_g_row == $past(r_g_row) + RW'(1)))
        else $error("row sequencer skipped or repeated a row");

endmodule
